// ===== hw/rtl/accumulator_cpu_step_top_defines.svh =====
// Assertion macros used by the accumulator machine controller.
`ifndef ACCUMULATOR_CPU_STEP_TOP_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ACS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acs check failed");
// Next-cycle implication, checked outside reset.
`define ACS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acs check failed");
`else
`define ACS_ASSERT_IMP(name, ante, cons)
`define ACS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hw/rtl/acs_pkg.sv =====
// Shared types and constants of the accumulator machine.
package acs_pkg;

  localparam int AddrW = 8;
  localparam int DataW = 8;
  localparam int MemDepth = 256;

  // Request operations.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STEP  = 2'd3;

  // Instruction opcodes; bit 7 marks an opcode that takes an operand address byte.
  localparam int         FetchBit   = 7;
  localparam logic [7:0] OPC_STOP   = 8'h01;
  localparam logic [7:0] OPC_RIGHT  = 8'h02;
  localparam logic [7:0] OPC_LEFT   = 8'h03;
  localparam logic [7:0] OPC_NOT    = 8'h04;
  localparam logic [7:0] OPC_AND    = 8'h81;
  localparam logic [7:0] OPC_OR     = 8'h82;
  localparam logic [7:0] OPC_XOR    = 8'h83;
  localparam logic [7:0] OPC_LOAD   = 8'h84;
  localparam logic [7:0] OPC_STORE  = 8'h85;
  localparam logic [7:0] OPC_ADD    = 8'h86;
  localparam logic [7:0] OPC_SUB    = 8'h87;
  localparam logic [7:0] OPC_GOTO   = 8'h88;
  localparam logic [7:0] OPC_IFZERO = 8'h89;

  localparam logic [7:0] ADDR_LAST = 8'hFF;

  // Memory read address selection.
  localparam logic [1:0] RSEL_REQ  = 2'd0;
  localparam logic [1:0] RSEL_PC   = 2'd1;
  localparam logic [1:0] RSEL_ADV  = 2'd2;
  localparam logic [1:0] RSEL_DATA = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] accumulator;
    logic [AddrW-1:0] program_counter;
    logic             halted;
    logic             error_flag;
    logic [DataW-1:0] read_data;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic [1:0] rsel;
    logic       mem_write;
    logic       load_start;
    logic       take_opc;
    logic       exec_short;
    logic       take_adr;
    logic       exec_long;
    logic       show_read;
    logic       finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic halted;
    logic fetch;
  } sts_t;

endpackage

// ===== hw/rtl/acs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write into the array; read data registered, so a read of the address being written returns the old content.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/acs_datapath.sv =====
// Datapath of the accumulator machine: registers, ALU and main memory.
module acs_datapath import acs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t request,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t result
);

  logic [DataW-1:0] acc, acc_next;
  logic [AddrW-1:0] pc, pc_next;
  logic             halt, halt_next;
  logic             err, err_next;
  logic [AddrW-1:0] nxt, nxt_next;
  logic [DataW-1:0] opc, opc_next;
  logic [AddrW-1:0] adr, adr_next;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [DataW-1:0] rdata;

  logic [AddrW-1:0] pc_adv;
  logic [DataW:0]   sum9;
  logic [DataW:0]   diff9;

  assign pc_adv = pc + 8'd1;
  assign sum9   = {1'b0, acc} + {1'b0, rdata};
  assign diff9  = {1'b0, acc} - {1'b0, rdata};

  assign sts.halted = halt;
  assign sts.fetch  = rdata[FetchBit];

  // Read address selection for the memory.
  always_comb begin
    unique case (cmd.rsel)
      RSEL_REQ:  mem_raddr = request.address;
      RSEL_PC:   mem_raddr = pc;
      RSEL_ADV:  mem_raddr = pc_adv;
      RSEL_DATA: mem_raddr = rdata;
      default:   mem_raddr = request.address;
    endcase
  end

  // Writes come from a write request or from a STORE instruction.
  always_comb begin
    mem_we    = cmd.mem_write || (cmd.exec_long && (opc == OPC_STORE));
    mem_waddr = cmd.exec_long ? adr : request.address;
    mem_wdata = cmd.exec_long ? acc : request.data;
  end

  acs_ram #(
    .WIDTH (DataW),
    .DEPTH (MemDepth)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Next architectural and working state.
  always_comb begin
    acc_next  = acc;
    pc_next   = pc;
    halt_next = halt;
    err_next  = err;
    nxt_next  = nxt;
    opc_next  = opc;
    adr_next  = adr;

    if (cmd.load_start) begin
      acc_next  = '0;
      halt_next = 1'b0;
      err_next  = 1'b0;
      pc_next   = request.address;
    end

    // Opcode byte arrives; the counter moves past it.
    if (cmd.take_opc) begin
      opc_next = rdata;
      nxt_next = pc_adv;
      err_next = err || (pc == ADDR_LAST);
    end

    // Instructions without an operand address finish here.
    if (cmd.exec_short) begin
      pc_next = pc_adv;
      unique case (rdata)
        OPC_STOP:  halt_next = 1'b1;
        OPC_RIGHT: acc_next = {1'b0, acc[DataW-1:1]};
        OPC_LEFT:  acc_next = {acc[DataW-2:0], 1'b0};
        OPC_NOT:   acc_next = ~acc;
        default:   ;
      endcase
    end

    // Address byte arrives; the counter moves past it too.
    if (cmd.take_adr) begin
      adr_next = rdata;
      nxt_next = nxt + 8'd1;
      err_next = err || (nxt == ADDR_LAST);
    end

    // Operand byte arrives for instructions with an address.
    if (cmd.exec_long) begin
      pc_next = nxt;
      unique case (opc)
        OPC_AND:  acc_next = acc & rdata;
        OPC_OR:   acc_next = acc | rdata;
        OPC_XOR:  acc_next = acc ^ rdata;
        OPC_LOAD: acc_next = rdata;
        OPC_ADD: begin
          acc_next = sum9[DataW-1:0];
          err_next = err || sum9[DataW];
        end
        OPC_SUB: begin
          acc_next = diff9[DataW-1:0];
          err_next = err || diff9[DataW];
        end
        OPC_GOTO: pc_next = adr;
        OPC_IFZERO: begin
          if (acc == '0) begin
            pc_next = adr;
          end
        end
        default: ;
      endcase
    end
  end

  // Architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pc   <= '0;
      halt <= 1'b0;
      err  <= 1'b0;
    end else begin
      acc  <= acc_next;
      pc   <= pc_next;
      halt <= halt_next;
      err  <= err_next;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    nxt <= nxt_next;
    opc <= opc_next;
    adr <= adr_next;
    if (cmd.finish) begin
      result.accumulator     <= acc_next;
      result.program_counter <= pc_next;
      result.halted          <= halt_next;
      result.error_flag      <= err_next;
      result.read_data       <= cmd.show_read ? rdata : '0;
    end
  end

endmodule

// ===== hw/rtl/acs_ctrl.sv =====
// Controller state machine that sequences each request of the accumulator machine.
`include "accumulator_cpu_step_top_defines.svh"
module acs_ctrl import acs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_ADR  = 3'd3;
  localparam logic [2:0] ST_OPR  = 3'd4;

  logic [2:0] state, state_next;

  assign busy = (state != ST_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (op)
            OP_WRITE: begin
              cmd.mem_write = 1'b1;
              cmd.finish    = 1'b1;
            end
            OP_READ: begin
              cmd.rsel   = RSEL_REQ;
              state_next = ST_READ;
            end
            OP_START: begin
              cmd.load_start = 1'b1;
              cmd.finish     = 1'b1;
            end
            OP_STEP: begin
              if (sts.halted) begin
                cmd.finish = 1'b1;
              end else begin
                cmd.rsel   = RSEL_PC;
                state_next = ST_DEC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.show_read = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_DEC: begin
        cmd.take_opc = 1'b1;
        if (sts.fetch) begin
          cmd.rsel   = RSEL_ADV;
          state_next = ST_ADR;
        end else begin
          cmd.exec_short = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_ADR: begin
        cmd.take_adr = 1'b1;
        cmd.rsel     = RSEL_DATA;
        state_next   = ST_OPR;
      end
      ST_OPR: begin
        cmd.exec_long = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  // A step on a running machine always goes on to fetch its opcode.
  `ACS_ASSERT_NEXT(a_step_fetches, start && !busy && (op == OP_STEP) && !sts.halted, busy)
  // The operand phase only follows the address phase.
  `ACS_ASSERT_IMP(a_opr_after_adr, state == ST_OPR, $past(state) == ST_ADR)
  // Every finished request raises done in the next cycle.
  `ACS_ASSERT_NEXT(a_finish_done, cmd.finish, done)

endmodule

// ===== hw/rtl/accumulator_cpu_step_top.sv =====
// Top level of the 8-bit accumulator machine with its 256-byte memory.
// Write, start and a step while halted finish in the accepting state; a read goes through READ,
// an instruction without an operand through DEC, and one with an operand through DEC, ADR and OPR.
// The next request is taken at the edge that ends the done cycle of the previous one,
// and a step makes up to three reads through the single read port, then executes.
// Synchronous reset clears accumulator, counter, halted and error; memory keeps its content.
// The result is shown for one cycle with done high; the receiver cannot stall it.
module accumulator_cpu_step_top import acs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  cmd_t cmd;
  sts_t sts;

  acs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (request.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  acs_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule
